>>> rtl/core/fqd_pkg.sv
`default_nettype none

package fqd_pkg;

    // Queue geometry.
    localparam int DEPTH    = 16;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int HANDLE_W = 32;
    localparam int FUNC_W   = 2;

    // Operation codes carried in the func field.
    localparam logic [FUNC_W-1:0] OP_ENQUEUE = 2'd0;
    localparam logic [FUNC_W-1:0] OP_DEQUEUE = 2'd1;
    localparam logic [FUNC_W-1:0] OP_DELETE  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DEQ,
        ST_SRCH,
        ST_SHIFT,
        ST_DEL_FIN
    } state_t;

    // Read address selection, relative to the head of the queue.
    typedef enum logic [1:0] {
        RD_HEAD,
        RD_NEXT,
        RD_SKIP
    } rd_sel_t;

    // Write address selection.
    typedef enum logic {
        WR_TAIL,
        WR_POS
    } wr_sel_t;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    pos_clr;
        logic    pos_inc;
        logic    occ_inc;
        logic    occ_dec;
        logic    head_inc;
        logic    finish;
        logic    fin_fail;
        logic    fin_deq;
    } cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] op;
        logic              handle_zero;
        logic              empty;
        logic              full;
        logic              match;
        logic              next_last;
        logic              skip_last;
        logic              out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> rtl/core/fqd_dpath.sv
`default_nettype none

module fqd_dpath
    import fqd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cmd_t                cmd,
    output sts_t                     sts,
    input  wire logic [FUNC_W-1:0]   func,
    input  wire logic [HANDLE_W-1:0] item_handle,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     status,
    output logic [HANDLE_W-1:0]      out_handle,
    output logic [CNT_W-1:0]         count
);

    logic [HANDLE_W-1:0] mem [DEPTH];

    logic [FUNC_W-1:0]   func_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [IDX_W-1:0]    head_reg;
    logic [IDX_W-1:0]    head_next;
    logic [CNT_W-1:0]    occ_reg;
    logic [CNT_W-1:0]    occ_next;
    logic [CNT_W-1:0]    pos_reg;
    logic [CNT_W-1:0]    pos_next;
    logic [HANDLE_W-1:0] rd_data_reg;
    logic                out_valid_reg;
    logic                status_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic [CNT_W-1:0]    count_reg;

    logic [CNT_W:0]      pos1;
    logic [CNT_W:0]      pos2;
    logic [CNT_W:0]      rd_off;
    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    wr_addr;
    logic [HANDLE_W-1:0] wr_data;

    // Physical slot of a queue position: head plus offset, wrapped once.
    function automatic logic [IDX_W-1:0] slot_of(
        input logic [IDX_W-1:0] base,
        input logic [CNT_W:0]   off
    );
        logic [CNT_W+1:0] sum;
        sum = {{(CNT_W + 2 - IDX_W){1'b0}}, base} + {1'b0, off};
        if (sum >= (CNT_W + 2)'(DEPTH))
        begin
            sum = sum - (CNT_W + 2)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign pos1 = {1'b0, pos_reg} + (CNT_W + 1)'(1);
    assign pos2 = {1'b0, pos_reg} + (CNT_W + 1)'(2);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_HEAD: rd_off = '0;
            RD_NEXT: rd_off = pos1;
            RD_SKIP: rd_off = pos2;
            default: rd_off = '0;
        endcase
    end

    assign rd_addr = slot_of(head_reg, rd_off);
    assign wr_addr = (cmd.wr_sel == WR_TAIL) ? slot_of(head_reg, {1'b0, occ_reg})
                                             : slot_of(head_reg, {1'b0, pos_reg});
    assign wr_data = (cmd.wr_sel == WR_TAIL) ? handle_reg : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (cmd.occ_inc)
        begin
            occ_next = occ_reg + CNT_W'(1);
        end
        else if (cmd.occ_dec)
        begin
            occ_next = occ_reg - CNT_W'(1);
        end

        head_next = head_reg;
        if (cmd.head_inc)
        begin
            head_next = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);
        end

        pos_next = pos_reg;
        if (cmd.pos_clr)
        begin
            pos_next = '0;
        end
        else if (cmd.pos_inc)
        begin
            pos_next = pos1[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            occ_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            occ_reg  <= occ_next;
            pos_reg  <= pos_next;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= func;
            handle_reg <= item_handle;
        end
        if (cmd.finish)
        begin
            status_reg     <= cmd.fin_fail;
            out_handle_reg <= cmd.fin_deq ? rd_data_reg : '0;
            count_reg      <= occ_next;
        end
    end

    assign sts.op          = func_reg;
    assign sts.handle_zero = (handle_reg == '0);
    assign sts.empty       = (occ_reg == '0);
    assign sts.full        = (occ_reg == CNT_W'(DEPTH));
    assign sts.match       = (rd_data_reg == handle_reg);
    assign sts.next_last   = (pos1 >= {1'b0, occ_reg});
    assign sts.skip_last   = (pos2 >= {1'b0, occ_reg});
    assign sts.out_free    = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign out_handle = out_handle_reg;
    assign count      = count_reg;

endmodule

`default_nettype wire

>>> rtl/core/fqd_ctrl.sv
`default_nettype none

module fqd_ctrl
    import fqd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                case (sts.op)
                    OP_ENQUEUE:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.finish = 1'b1;
                            if (sts.handle_zero || sts.full)
                            begin
                                cmd.fin_fail = 1'b1;
                            end
                            else
                            begin
                                cmd.wr_en   = 1'b1;
                                cmd.wr_sel  = WR_TAIL;
                                cmd.occ_inc = 1'b1;
                            end
                            state_next = ST_IDLE;
                        end
                    end
                    OP_DEQUEUE:
                    begin
                        if (sts.empty)
                        begin
                            if (sts.out_free)
                            begin
                                cmd.finish   = 1'b1;
                                cmd.fin_fail = 1'b1;
                                state_next   = ST_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_HEAD;
                            state_next = ST_DEQ;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (sts.handle_zero || sts.empty)
                        begin
                            if (sts.out_free)
                            begin
                                cmd.finish   = 1'b1;
                                cmd.fin_fail = 1'b1;
                                state_next   = ST_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_sel  = RD_HEAD;
                            cmd.pos_clr = 1'b1;
                            state_next  = ST_SRCH;
                        end
                    end
                    default:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.finish   = 1'b1;
                            cmd.fin_fail = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end
                endcase
            end

            ST_DEQ:
            begin
                if (sts.out_free)
                begin
                    cmd.finish   = 1'b1;
                    cmd.fin_deq  = 1'b1;
                    cmd.occ_dec  = 1'b1;
                    cmd.head_inc = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            ST_SRCH:
            begin
                if (sts.match)
                begin
                    if (sts.next_last)
                    begin
                        state_next = ST_DEL_FIN;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_NEXT;
                        state_next = ST_SHIFT;
                    end
                end
                else if (sts.next_last)
                begin
                    if (sts.out_free)
                    begin
                        cmd.finish   = 1'b1;
                        cmd.fin_fail = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = RD_NEXT;
                    cmd.pos_inc = 1'b1;
                end
            end

            ST_SHIFT:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_POS;
                cmd.pos_inc = 1'b1;
                if (sts.skip_last)
                begin
                    state_next = ST_DEL_FIN;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_SKIP;
                end
            end

            ST_DEL_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.finish  = 1'b1;
                    cmd.occ_dec = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/fifo_queue_with_delete.sv
// An enqueue, an unknown operation and a dequeue or delete that fails at once finish in
// the execute state; a dequeue reads the head, then finishes in its own state.
// The block holds one item at a time and takes the next only once a result is loaded. A
// delete walks the entry store one position per cycle, searching and then compacting.
// Reset: rst_n is asynchronous and active low; it empties the queue and drops any
// pending result. The entry store itself is not cleared.
`default_nettype none

module fifo_queue_with_delete
    import fqd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [FUNC_W-1:0]   func,
    input  wire logic [HANDLE_W-1:0] item_handle,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     status,
    output logic [HANDLE_W-1:0]      out_handle,
    output logic [CNT_W-1:0]         count
);

    // The controller sequences each item; the datapath holds the circular entry
    // store, the head and occupancy registers, the walk position and the result
    // register. They talk only through the command and status structs below.
    cmd_t cmd;
    sts_t sts;

    // The controller takes one item at a time. An item is latched on acceptance,
    // executed, and its result is loaded into the output register once that
    // register is free, so a stalled consumer holds the walk in its final state
    // without disturbing the queue.
    fqd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // A delete first reads entries from the head until one matches, then copies
    // each later entry one slot toward the head, reading the next entry in the
    // same cycle as it writes the current one, and finally shortens the queue.
    fqd_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .func        (func),
        .item_handle (item_handle),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .out_handle  (out_handle),
        .count       (count)
    );

endmodule

`default_nettype wire

>>> rtl/core/fqd_checker.sv
`default_nettype none

module fqd_checker
    import fqd_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic [FUNC_W-1:0]   func,
    input wire logic [HANDLE_W-1:0] item_handle,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire logic                status,
    input wire logic [HANDLE_W-1:0] out_handle,
    input wire logic [CNT_W-1:0]    count
);

    // A result that is not taken holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_handle)
                                    && $stable(count))
        else $error("result changed while stalled");

    // A failed request never returns a handle.
    a_fail_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> out_handle == '0)
        else $error("failed result carries a handle");

    // The reported length never exceeds the store size.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count <= CNT_W'(DEPTH))
        else $error("count beyond depth");

    // A dequeue that returned a handle leaves room for at least one entry.
    a_deq_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !status && out_handle != '0 |-> count < CNT_W'(DEPTH))
        else $error("dequeue left a full queue");

endmodule

bind fifo_queue_with_delete fqd_checker u_fqd_checker (.*);

`default_nettype wire

>>> tb/sv/fifo_queue_with_delete_tb.sv
`default_nettype none

module fifo_queue_with_delete_tb
    import fqd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Status codes carried on the status output, and the func value that
    // names no operation.
    localparam logic              STATUS_OK  = 1'b0;
    localparam logic              STATUS_ERR = 1'b1;
    localparam logic [FUNC_W-1:0] OP_UNKNOWN = 2'd3;

    // Number of random items sent after the directed part.
    localparam int RANDOM_ITEMS = 1875;

    // A delete may walk and compact the whole store, so the quiet time at the
    // end is longer than one full walk.
    localparam int SETTLE_CYCLES = DEPTH + 8;

    // Share of cycles, in percent, in which either side idles.
    localparam int IDLE_PERCENT = 20;

    typedef struct packed {
        logic                status;
        logic [HANDLE_W-1:0] handle;
        logic [CNT_W-1:0]    count;
    } queue_result_t;

    // Operation mixes used by the random traffic phases.
    typedef enum logic [1:0] {
        MODE_FILL,
        MODE_DRAIN,
        MODE_DELETE,
        MODE_MIXED
    } traffic_mode_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    logic [FUNC_W-1:0]   func        = OP_ENQUEUE;
    logic [HANDLE_W-1:0] item_handle = '0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    logic                status;
    logic [HANDLE_W-1:0] out_handle;
    logic [CNT_W-1:0]    count;

    // Contents of the queue as the testbench sees them, head first.
    logic [HANDLE_W-1:0] model_entries[$];

    // Results predicted at acceptance and not yet seen on the output.
    queue_result_t       pending_results[$];

    int  error_count = 0;
    int  random_sent = 0;

    // When set, neither side idles: the sender offers items back to back and
    // the receiver holds out_ready high.
    bit  calm = 1'b0;

    fifo_queue_with_delete u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .item_handle (item_handle),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .out_handle  (out_handle),
        .count       (count)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Applies one operation to the testbench's copy of the queue and returns
    // the result the block should give for it. Every failure leaves the copy
    // unchanged, and the returned count is always the length afterwards.
    function automatic queue_result_t predict_queue_op(input logic [FUNC_W-1:0]   op,
                                                       input logic [HANDLE_W-1:0] h);
        queue_result_t r;
        int            pos;
        r.status = STATUS_ERR;
        r.handle = '0;
        pos      = -1;
        case (op)
            OP_ENQUEUE:
            begin
                if (h != '0 && model_entries.size() < DEPTH)
                begin
                    model_entries.push_back(h);
                    r.status = STATUS_OK;
                end
            end
            OP_DEQUEUE:
            begin
                if (model_entries.size() != 0)
                begin
                    r.handle = model_entries.pop_front();
                    r.status = STATUS_OK;
                end
            end
            OP_DELETE:
            begin
                // Only the first match counted from the head is removed.
                if (h != '0)
                begin
                    for (int i = 0; i < model_entries.size(); i++)
                    begin
                        if (pos < 0 && model_entries[i] == h)
                        begin
                            pos = i;
                        end
                    end
                    if (pos >= 0)
                    begin
                        model_entries.delete(pos);
                        r.status = STATUS_OK;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.count = CNT_W'(model_entries.size());
        return r;
    endfunction

    // Prints one line for a mismatch and counts it. Printing stops after a
    // few dozen lines so that a broken block cannot flood the log, but every
    // mismatch is still counted.
    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 40)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // Offers one item and returns at the clock edge at which it is accepted.
    // valid stays high on return, so a following item with no gap keeps it
    // high and only changes the payload in the same step.
    task automatic send_request(input logic [FUNC_W-1:0]   op,
                                input logic [HANDLE_W-1:0] h);
        int gap;
        if (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= op;
        item_handle <= h;
        do
        begin
            @(posedge clk);
        end
        while (!(in_valid && in_ready));
        pending_results.push_back(predict_queue_op(op, h));
    endtask

    // Lowers valid and waits until every predicted result has come out.
    task automatic wait_for_results;
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Handles drawn from a small set, so that the queue often holds the same
    // handle more than once and a delete has to pick the first copy.
    function automatic logic [HANDLE_W-1:0] pool_handle;
        case ($urandom_range(7))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h0000_0001;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h5555_AAAA;
            5:       return 32'hAAAA_5555;
            6:       return 32'h0000_0100;
            default: return 32'h1234_5678;
        endcase
    endfunction

    function automatic logic [HANDLE_W-1:0] random_handle;
        return $urandom;
    endfunction

    function automatic logic [HANDLE_W-1:0] pick_enqueue_handle;
        int roll;
        roll = $urandom_range(99);
        if (roll < 6)
        begin
            return '0;
        end
        if (roll < 50)
        begin
            return pool_handle();
        end
        return random_handle();
    endfunction

    // Deletes mostly name a handle that is in the queue, at any position, so
    // that the search and the compaction are walked over every distance.
    function automatic logic [HANDLE_W-1:0] pick_delete_handle;
        int roll;
        roll = $urandom_range(99);
        if (model_entries.size() != 0 && roll < 65)
        begin
            return model_entries[$urandom_range(model_entries.size() - 1)];
        end
        if (roll < 72)
        begin
            return '0;
        end
        if (roll < 86)
        begin
            return pool_handle();
        end
        return random_handle();
    endfunction

    // Sends one random item whose operation is drawn from the mix of the
    // given mode.
    task automatic send_random_request(input traffic_mode_t mode);
        int roll;
        int enq_limit;
        int deq_limit;
        int del_limit;
        roll = $urandom_range(99);
        case (mode)
            MODE_FILL:
            begin
                enq_limit = 65;
                deq_limit = 80;
                del_limit = 97;
            end
            MODE_DRAIN:
            begin
                enq_limit = 15;
                deq_limit = 75;
                del_limit = 97;
            end
            MODE_DELETE:
            begin
                enq_limit = 40;
                deq_limit = 50;
                del_limit = 97;
            end
            default:
            begin
                enq_limit = 35;
                deq_limit = 65;
                del_limit = 97;
            end
        endcase
        if (roll < enq_limit)
        begin
            send_request(OP_ENQUEUE, pick_enqueue_handle());
        end
        else if (roll < deq_limit)
        begin
            send_request(OP_DEQUEUE, random_handle());
        end
        else if (roll < del_limit)
        begin
            send_request(OP_DELETE, pick_delete_handle());
        end
        else
        begin
            send_request(OP_UNKNOWN, random_handle());
        end
        random_sent++;
    endtask

    // Every operation on an empty queue fails and leaves the length at zero,
    // and so does a null enqueue and an unknown operation.
    task automatic test_empty_queue;
        send_request(OP_DEQUEUE, 32'hFFFF_FFFF);
        send_request(OP_DELETE, 32'h0000_0001);
        send_request(OP_ENQUEUE, '0);
        send_request(OP_UNKNOWN, 32'hFFFF_FFFF);
        wait_for_results();
    endtask

    // Fills the queue to its depth, with the extreme handles and some
    // repeated ones among the entries, then tries one enqueue too many.
    task automatic test_fill_to_full;
        send_request(OP_ENQUEUE, 32'h0000_0001);
        send_request(OP_ENQUEUE, 32'hFFFF_FFFF);
        send_request(OP_ENQUEUE, 32'h8000_0000);
        send_request(OP_ENQUEUE, 32'h5555_AAAA);
        send_request(OP_ENQUEUE, 32'h7FFF_FFFF);
        send_request(OP_ENQUEUE, 32'h5555_AAAA);
        for (int i = 0; i < DEPTH - 7; i++)
        begin
            send_request(OP_ENQUEUE, random_handle() | 32'h1);
        end
        send_request(OP_ENQUEUE, 32'hDEAD_0001);
        send_request(OP_ENQUEUE, 32'hDEAD_0002);
    endtask

    // Delete on a full queue: a null handle and a handle that is not held
    // both fail, a repeated handle loses only its first copy, the newest
    // entry can be removed, and the head still comes out in order afterwards.
    task automatic test_delete_cases;
        send_request(OP_DELETE, '0);
        send_request(OP_DELETE, 32'hDEAD_BEEF);
        send_request(OP_DELETE, 32'h5555_AAAA);
        send_request(OP_DELETE, 32'hDEAD_0001);
        send_request(OP_DEQUEUE, '0);
        wait_for_results();
    endtask

    // Random traffic in phases of different operation mixes, so that the
    // queue swings between empty and full and the head wraps around the
    // store many times. One phase runs with no idling at all, and after it and
    // one later phase the sender stops until every predicted result has come out.
    task automatic test_random_traffic;
        int            phase;
        int            phase_len;
        traffic_mode_t mode;
        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            phase_len = $urandom_range(20, 60);
            mode      = traffic_mode_t'($urandom_range(3));
            calm      = 1'b0;
            if (phase == 3)
            begin
                calm      = 1'b1;
                phase_len = 150;
                mode      = MODE_MIXED;
            end
            for (int i = 0; i < phase_len && random_sent < RANDOM_ITEMS; i++)
            begin
                send_random_request(mode);
            end
            if (phase == 3 || phase == 8)
            begin
                wait_for_results();
            end
            phase++;
        end
        calm = 1'b0;
        wait_for_results();
    endtask

    // The receiver stalls at random, except while the calm stretch runs.
    always @(posedge clk)
    begin
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Each accepted result is checked against the oldest prediction.
    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result status=%0d handle=%h count=%0d",
                                          status, out_handle, count));
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    report_mismatch($sformatf("status got %b want %b", status, want.status));
                end
                if (out_handle !== want.handle)
                begin
                    report_mismatch($sformatf("out_handle got %h want %h",
                                              out_handle, want.handle));
                end
                if (count !== want.count)
                begin
                    report_mismatch($sformatf("count got %0d want %0d", count, want.count));
                end
            end
        end
    end

    // A run that takes far longer than the slowest correct one has hung.
    initial
    begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_fill_to_full();
        test_delete_cases();
        test_random_traffic();

        // Let the block sit idle for longer than one full delete walk, so
        // that any stray result would show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d predicted results never came out",
                                      pending_results.size()));
        end

        if (error_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
